[rtl/core/bcg_beat_rate_detector_core_assert.svh]
// Assertion macros shared by the beat-rate detector core.
// Depends on nothing; included by modules that carry assertions.
`ifndef BCG_BEAT_RATE_DETECTOR_CORE_ASSERT_SVH
`define BCG_BEAT_RATE_DETECTOR_CORE_ASSERT_SVH
// Check a condition at every clock edge outside reset
`define BCG_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bcg assertion failed");
// Check that a condition in the next cycle follows from a condition now
`define BCG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcg assertion failed");
`endif

[rtl/core/bcg_pkg.sv]
// Shared types, constants and helper functions of the beat-rate detector.
// Depends on nothing; used by every module of the core.
`timescale 1ns / 1ps
package bcg_pkg;
   localparam int MEDIAN_DEPTH_DEF = 5;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 20;

   // Register indexes
   localparam logic [CSR_IW-1:0] REG_HP_COEFF   = 3'd0;
   localparam logic [CSR_IW-1:0] REG_LP_COEFF   = 3'd1;
   localparam logic [CSR_IW-1:0] REG_ENV_DECAY  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_THR_RATIO  = 3'd3;
   localparam logic [CSR_IW-1:0] REG_THR_FLOOR  = 3'd4;
   localparam logic [CSR_IW-1:0] REG_REFRACTORY = 3'd5;
   localparam logic [CSR_IW-1:0] REG_STALE      = 3'd6;

   // Register reset values
   localparam logic [15:0] HP_COEFF_RST   = 16'd31932;
   localparam logic [15:0] LP_COEFF_RST   = 16'd9247;
   localparam logic [15:0] ENV_DECAY_RST  = 16'd32702;
   localparam logic [15:0] THR_RATIO_RST  = 16'd13107;
   localparam logic [19:0] THR_FLOOR_RST  = 20'd3146;
   localparam logic [15:0] REFRACTORY_RST = 16'd400;
   localparam logic [15:0] STALE_RST      = 16'd2000;

   // Rate divider: 60000 * 16 over the median interval
   localparam int DIV_W = 20;
   localparam logic [DIV_W-1:0] RATE_NUM = 20'd960000;
   localparam logic [11:0] RATE_MAX = 12'd4095;
   localparam logic [4:0] DIV_LAST = 5'd19;

   // Operand selection of the shared Q1.15 multiplier
   localparam logic [1:0] OP_HP  = 2'd0;
   localparam logic [1:0] OP_LP  = 2'd1;
   localparam logic [1:0] OP_ENV = 2'd2;
   localparam logic [1:0] OP_THR = 2'd3;

   typedef struct packed {
      logic       load;
      logic       op_load;
      logic       mul;
      logic       acc;
      logic [1:0] opsel;
      logic       med_step;
      logic       div_step;
      logic       stale;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic need_rate;
      logic med_found;
      logic div_done;
      logic out_free;
   } sts_type;

   // Saturate a signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sh0080000000) begin
         r = -32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage

[rtl/core/bcg_if.sv]
// Valid/ready channel interfaces for the beat-rate detector core.
// Depends on nothing; the sample width is a parameter.
`timescale 1ns / 1ps
interface bcg_req_if #(parameter int SW = 16);
   logic                 valid;
   logic                 ready;
   logic signed [SW-1:0] accel_sample;
   logic [31:0]          now_ms;
   modport source (output valid, accel_sample, now_ms, input ready);
   modport sink (input valid, accel_sample, now_ms, output ready);
endinterface

interface bcg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] filtered;
   logic               beat;
   logic [11:0]        rate_x16;
   logic [31:0]        beat_total;
   modport source (output valid, filtered, beat, rate_x16, beat_total, input ready);
   modport sink (input valid, filtered, beat, rate_x16, beat_total, output ready);
endinterface

[rtl/core/bcg_beat_rate_detector_core.sv]
// Beat-rate detector for a vertical acceleration stream.
// Channels: req_chan takes one sample word (accel_sample, now_ms); rsp_chan
// returns one result word per sample (filtered, beat, rate_x16, beat_total).
// Both use valid/ready; a word moves on a clock edge with both high.
// csr_we/csr_index/csr_wdata write the seven tuning registers; write them
// only while no sample is in flight.
// A sample runs the high-pass, low-pass, envelope and threshold steps (each
// an operand load, multiply and accumulate), the stale check and the output
// step; a beat that stores an interval adds a median search and the rate
// divider. One sample is worked at a time through a single shared Q1.15
// multiplier, so a new sample is taken only once the last has been output.
// A finished result waits in an output register; the core takes the next
// sample meanwhile and holds its own result until the register is free.
// Reset (synchronous, active high) clears the filters, envelope, beat
// counter and rate and restores the register defaults; no clearing pass.
// Depends on bcg_pkg, bcg_if, bcg_ctrl and bcg_dp.
`timescale 1ns / 1ps
module bcg_beat_rate_detector_core #(
   parameter int MEDIAN_DEPTH = bcg_pkg::MEDIAN_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = bcg_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   bcg_req_if.sink                    req_chan,
   bcg_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [bcg_pkg::CSR_IW-1:0] csr_index,
   input  logic [bcg_pkg::CSR_DW-1:0] csr_wdata
);
   import bcg_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcg_dp #(
      .MEDIAN_DEPTH (MEDIAN_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .accel_sample   (req_chan.accel_sample),
      .now_ms         (req_chan.now_ms),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_filtered   (rsp_chan.filtered),
      .rsp_beat       (rsp_chan.beat),
      .rsp_rate_x16   (rsp_chan.rate_x16),
      .rsp_beat_total (rsp_chan.beat_total)
   );
endmodule

[rtl/core/bcg_ctrl.sv]
// Sequencer of the beat-rate detector: steps the datapath through one sample.
// Depends on bcg_pkg.
`timescale 1ns / 1ps
module bcg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcg_pkg::sts_type sts,
   output bcg_pkg::cmd_type cmd
);
   import bcg_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_HP_OPD = 5'd1;
   localparam logic [4:0] S_HP_MUL = 5'd2;
   localparam logic [4:0] S_HP_ACC = 5'd3;
   localparam logic [4:0] S_LP_OPD = 5'd4;
   localparam logic [4:0] S_LP_MUL = 5'd5;
   localparam logic [4:0] S_LP_ACC = 5'd6;
   localparam logic [4:0] S_EN_OPD = 5'd7;
   localparam logic [4:0] S_EN_MUL = 5'd8;
   localparam logic [4:0] S_EN_ACC = 5'd9;
   localparam logic [4:0] S_TH_OPD = 5'd10;
   localparam logic [4:0] S_TH_MUL = 5'd11;
   localparam logic [4:0] S_DECIDE = 5'd12;
   localparam logic [4:0] S_MED    = 5'd13;
   localparam logic [4:0] S_DIV    = 5'd14;
   localparam logic [4:0] S_STALE  = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   logic [4:0] state_ff, state_in;

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
            if (req_valid) state_in = S_HP_OPD;
         end
         S_HP_OPD: begin cmd.op_load = 1'b1; cmd.opsel = OP_HP;  state_in = S_HP_MUL; end
         S_HP_MUL: begin cmd.mul = 1'b1; state_in = S_HP_ACC; end
         S_HP_ACC: begin cmd.acc = 1'b1; cmd.opsel = OP_HP;  state_in = S_LP_OPD; end
         S_LP_OPD: begin cmd.op_load = 1'b1; cmd.opsel = OP_LP;  state_in = S_LP_MUL; end
         S_LP_MUL: begin cmd.mul = 1'b1; state_in = S_LP_ACC; end
         S_LP_ACC: begin cmd.acc = 1'b1; cmd.opsel = OP_LP;  state_in = S_EN_OPD; end
         S_EN_OPD: begin cmd.op_load = 1'b1; cmd.opsel = OP_ENV; state_in = S_EN_MUL; end
         S_EN_MUL: begin cmd.mul = 1'b1; state_in = S_EN_ACC; end
         S_EN_ACC: begin cmd.acc = 1'b1; cmd.opsel = OP_ENV; state_in = S_TH_OPD; end
         S_TH_OPD: begin cmd.op_load = 1'b1; cmd.opsel = OP_THR; state_in = S_TH_MUL; end
         S_TH_MUL: begin cmd.mul = 1'b1; state_in = S_DECIDE; end
         S_DECIDE: begin cmd.acc = 1'b1; cmd.opsel = OP_THR; state_in = S_STALE; end
         S_MED: begin
            cmd.med_step = 1'b1;
            if (sts.med_found) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_STALE;
         end
         S_STALE: begin cmd.stale = 1'b1; state_in = S_OUT; end
         S_OUT: begin
            cmd.emit = sts.out_free;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // a new interval sends the decision through the median and divider
      if (state_ff == S_DECIDE && sts.need_rate) state_in = S_MED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[rtl/core/bcg_dp.sv]
// Datapath of the beat-rate detector: filters, envelope, beat test, interval
// ring, median search and rate divider. Depends on bcg_pkg and the assert macros.
`timescale 1ns / 1ps
`include "bcg_beat_rate_detector_core_assert.svh"
module bcg_dp #(
   parameter int MEDIAN_DEPTH = bcg_pkg::MEDIAN_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = bcg_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bcg_pkg::cmd_type               cmd,
   output bcg_pkg::sts_type               sts,
   input  logic signed [SAMPLE_WIDTH-1:0] accel_sample,
   input  logic [31:0]                    now_ms,
   input  logic                           csr_we,
   input  logic [bcg_pkg::CSR_IW-1:0]     csr_index,
   input  logic [bcg_pkg::CSR_DW-1:0]     csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [16:0]             rsp_filtered,
   output logic                           rsp_beat,
   output logic [11:0]                    rsp_rate_x16,
   output logic [31:0]                    rsp_beat_total
);
   import bcg_pkg::*;

   localparam int SW  = SAMPLE_WIDTH;
   localparam int D   = MEDIAN_DEPTH;
   localparam int AW  = ((SW + 9 > 33) ? SW + 9 : 33) + 1;
   localparam int IXW = (D > 1) ? $clog2(D) : 1;
   localparam int CW  = $clog2(D + 1);
   localparam logic [CW-1:0] DEPTH = CW'(D);

   // Configuration registers
   logic [15:0] hp_coeff_ff, lp_coeff_ff, env_decay_ff, thr_ratio_ff;
   logic [19:0] thr_floor_ff;
   logic [15:0] refractory_ff, stale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_coeff_ff   <= HP_COEFF_RST;
         lp_coeff_ff   <= LP_COEFF_RST;
         env_decay_ff  <= ENV_DECAY_RST;
         thr_ratio_ff  <= THR_RATIO_RST;
         thr_floor_ff  <= THR_FLOOR_RST;
         refractory_ff <= REFRACTORY_RST;
         stale_ff      <= STALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_HP_COEFF:   hp_coeff_ff   <= csr_wdata[15:0];
            REG_LP_COEFF:   lp_coeff_ff   <= csr_wdata[15:0];
            REG_ENV_DECAY:  env_decay_ff  <= csr_wdata[15:0];
            REG_THR_RATIO:  thr_ratio_ff  <= csr_wdata[15:0];
            REG_THR_FLOOR:  thr_floor_ff  <= csr_wdata;
            REG_REFRACTORY: refractory_ff <= csr_wdata[15:0];
            REG_STALE:      stale_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Sample word and state
   logic signed [SW-1:0] x_ff, prev_ff;
   logic [31:0]          now_ff;
   logic signed [31:0]   hp_ff, lp_ff;
   logic [31:0]          env_ff, prev_abs_ff, af_ff, last_ff, count_ff;
   logic [IXW-1:0]       idx_ff, cand_ff;
   logic [CW-1:0]        fill_ff;
   logic [11:0]          rate_ff;
   logic                 beat_ff;
   logic [15:0]          ring_ff [D];

   // Shared multiplier operands and product
   logic [AW-1:0]    op_mag_ff;
   logic             op_neg_ff;
   logic [15:0]      op_coef_ff;
   logic [AW+15:0]   prod_ff;

   // Form the operand of the selected filter step
   logic signed [SW:0]   diff;
   logic signed [AW-1:0] hp_arg, lp_arg, arg;
   logic [15:0]          coef_sel;
   always_comb begin
      diff   = {x_ff[SW-1], x_ff} - {prev_ff[SW-1], prev_ff};
      hp_arg = {{(AW-32){hp_ff[31]}}, hp_ff}
               + {{(AW-SW-8){diff[SW]}}, diff, 7'b0};
      lp_arg = {{(AW-32){hp_ff[31]}}, hp_ff} - {{(AW-32){lp_ff[31]}}, lp_ff};
      case (cmd.opsel)
         OP_HP:   begin arg = hp_arg; coef_sel = hp_coeff_ff; end
         OP_LP:   begin arg = lp_arg; coef_sel = lp_coeff_ff; end
         OP_ENV:  begin arg = AW'(env_ff); coef_sel = env_decay_ff; end
         default: begin arg = AW'(env_ff); coef_sel = thr_ratio_ff; end
      endcase
   end

   // Round the product half away from zero and restore the sign
   logic [AW+16:0]       rnd;
   logic [AW+1:0]        rmag;
   logic signed [AW+2:0] sval;
   logic signed [39:0]   lp_sum;
   logic [31:0]          rsat, af_new, thresh;
   logic                 beat_hit;
   logic [31:0]          since;
   logic [31:0]          iv_full;
   logic [15:0]          iv;
   logic [IXW-1:0]       widx;
   always_comb begin
      rnd    = (AW+17)'(prod_ff) + (AW+17)'(16384);
      rmag   = rnd[AW+16:15];
      sval   = op_neg_ff ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      lp_sum = 40'(sval) + 40'(lp_ff);
      rsat   = (|rmag[AW+1:32]) ? 32'hFFFF_FFFF : rmag[31:0];
      af_new = lp_ff[31] ? (32'd0 - lp_ff) : lp_ff;
      thresh = (rsat < {12'd0, thr_floor_ff}) ? {12'd0, thr_floor_ff} : rsat;
      since  = now_ff - last_ff;
      beat_hit = (prev_abs_ff > af_ff) && (prev_abs_ff > thresh)
                 && (since > {16'd0, refractory_ff});
      iv_full = since;
      iv      = (|iv_full[31:16]) ? 16'hFFFF : iv_full[15:0];
      widx    = (32'(idx_ff) >= 32'(D)) ? '0 : idx_ff;
   end

   // Rank of the median candidate among the filled ring entries
   logic [15:0]   cand_val;
   logic [CW-1:0] rank;
   always_comb begin
      cand_val = ring_ff[cand_ff];
      rank = '0;
      for (int j = 0; j < D; j++) begin
         if (CW'(j) < fill_ff && ((ring_ff[j] < cand_val)
             || (ring_ff[j] == cand_val && IXW'(j) < cand_ff))) begin
            rank = rank + CW'(1);
         end
      end
   end
   assign sts.med_found = cmd.med_step && (rank == (fill_ff >> 1));

   // Restoring divider, one quotient bit a cycle
   logic [15:0]      med_ff, rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [4:0]       div_cnt_ff;
   logic [16:0]      rem2;
   logic             ge;
   logic [DIV_W-1:0] quo_next;
   always_comb begin
      rem2     = {rem_ff, quo_ff[DIV_W-1]};
      ge       = rem2 >= {1'b0, med_ff};
      quo_next = {quo_ff[DIV_W-2:0], ge};
   end
   assign sts.div_done = cmd.div_step && (div_cnt_ff == DIV_LAST);

   // Output rounding to 2^-13 g
   logic [25:0]        fmag;
   logic signed [16:0] filt;
   always_comb begin
      fmag = 26'((33'(af_ff) + 33'd64) >> 7);
      if (!lp_ff[31]) begin
         filt = (fmag > 26'd65535) ? 17'sd65535 : $signed({1'b0, fmag[15:0]});
      end else begin
         filt = (fmag > 26'd65536) ? -17'sd65536 : -$signed(fmag[16:0]);
      end
   end

   logic stale_hit;
   assign stale_hit = (last_ff != 32'd0) && (since > {16'd0, stale_ff});

   // Filter and decision state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         hp_ff        <= '0;
         lp_ff        <= '0;
         env_ff       <= '0;
         prev_abs_ff  <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         fill_ff      <= '0;
         rate_ff      <= '0;
         beat_ff      <= 1'b0;
         cand_ff      <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (cmd.load) begin
            beat_ff <= 1'b0;
         end
         if (cmd.acc) begin
            case (cmd.opsel)
               OP_HP: begin
                  hp_ff   <= sat32(40'(sval));
                  prev_ff <= x_ff;
               end
               OP_LP:  lp_ff <= sat32(lp_sum);
               OP_ENV: env_ff <= (af_ff > rsat) ? af_ff : rsat;
               default: begin
                  prev_abs_ff <= af_ff;
                  if (beat_hit) begin
                     last_ff  <= now_ff;
                     count_ff <= count_ff + 32'd1;
                     beat_ff  <= 1'b1;
                     if (last_ff != 32'd0) begin
                        cand_ff <= '0;
                        idx_ff  <= (32'(widx) == 32'(D - 1)) ? '0 : widx + IXW'(1);
                        if (fill_ff < DEPTH) fill_ff <= fill_ff + CW'(1);
                     end
                  end
               end
            endcase
         end
         if (cmd.med_step && !sts.med_found) cand_ff <= cand_ff + IXW'(1);
         if (sts.med_found) div_cnt_ff <= '0;
         if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 5'd1;
            if (sts.div_done) begin
               if (med_ff == 16'd0) begin
                  rate_ff <= '0;
               end else begin
                  rate_ff <= (quo_next > DIV_W'(RATE_MAX)) ? RATE_MAX : quo_next[11:0];
               end
            end
         end
         if (cmd.stale && stale_hit) begin
            rate_ff <= '0;
            fill_ff <= '0;
            idx_ff  <= '0;
         end
      end
   end

   // Payload registers: sample word, multiplier, ring, divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= accel_sample;
         now_ff <= now_ms;
      end
      if (cmd.op_load) begin
         op_neg_ff  <= arg[AW-1];
         op_mag_ff  <= arg[AW-1] ? (AW'(0) - arg) : arg;
         op_coef_ff <= coef_sel;
         if (cmd.opsel == OP_ENV) af_ff <= af_new;
      end
      if (cmd.mul) prod_ff <= (AW+16)'(op_mag_ff) * (AW+16)'(op_coef_ff);
      if (cmd.acc && cmd.opsel == OP_THR && beat_hit && last_ff != 32'd0) begin
         ring_ff[widx] <= iv;
      end
      if (sts.med_found) begin
         med_ff <= cand_val;
         rem_ff <= '0;
         quo_ff <= RATE_NUM + DIV_W'(cand_val >> 1);
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? 16'(rem2 - {1'b0, med_ff}) : rem2[15:0];
         quo_ff <= quo_next;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_filtered   <= filt;
         rsp_beat       <= beat_ff;
         rsp_rate_x16   <= rate_ff;
         rsp_beat_total <= count_ff;
      end
   end

   // A beat that closes an interval needs a new rate; read in the decision step
   assign sts.need_rate = beat_hit && (last_ff != 32'd0);
   assign sts.out_free  = !rsp_valid || rsp_ready;

   `BCG_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= DEPTH)
   `BCG_ASSERT_ALWAYS(a_idx_bound, clock, reset, 32'(idx_ff) < 32'(D))
   `BCG_ASSERT_NEXT(a_stale_clears, clock, reset, cmd.stale && stale_hit, rate_ff == 12'd0 && fill_ff == '0)
endmodule

[bench/tb_top.sv]
// Self-checking bench for the beat-rate detector core: drives sample words,
// predicts every result word and compares them field by field.
// Depends on bcg_pkg, bcg_if and bcg_beat_rate_detector_core.
`timescale 1ns / 1ps
module tb_top;
   import bcg_pkg::*;

   localparam longint U32_MASK = 64'd4294967295;
   localparam int RING_DEPTH = 5;
   localparam int SETTLE_CYCLES = 100;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      logic signed [16:0] filtered;
      logic               beat;
      logic [11:0]        rate_x16;
      logic [31:0]        beat_total;
   } beat_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   bcg_req_if #(.SW(16)) req ();
   bcg_rsp_if rsp ();

   bcg_beat_rate_detector_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Predictor state and its copy of the tuning registers
   longint hp_alpha, lp_alpha, env_decay, thr_ratio, thr_floor, refractory, stale_gap;
   longint prev_sample, hp_state, lp_state, env_level, prev_mag, last_beat;
   longint interval_ring [RING_DEPTH];
   int ring_pos, ring_count;
   longint rate_now, beats_seen;

   beat_word_t expected_words [$];
   int mismatches = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   logic [31:0] clock_ms = 32'd0;
   longint cycle_count = 0;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Signed value times a Q1.15 factor, rounded half away from zero
   function automatic longint scale_q15(longint a, longint c);
      longint m;
      m = (a < 0) ? -a : a;
      m = (m * c + 16384) >>> 15;
      return (a < 0) ? -m : m;
   endfunction

   function automatic longint uscale_q15(longint a, longint c);
      longint r;
      r = (a * c + 16384) >>> 15;
      return (r > U32_MASK) ? U32_MASK : r;
   endfunction

   task automatic reset_predictor();
      hp_alpha = HP_COEFF_RST; lp_alpha = LP_COEFF_RST; env_decay = ENV_DECAY_RST;
      thr_ratio = THR_RATIO_RST; thr_floor = THR_FLOOR_RST;
      refractory = REFRACTORY_RST; stale_gap = STALE_RST;
      prev_sample = 0; hp_state = 0; lp_state = 0; env_level = 0; prev_mag = 0;
      last_beat = 0; ring_pos = 0; ring_count = 0; rate_now = 0; beats_seen = 0;
      foreach (interval_ring[i]) interval_ring[i] = 0;
   endtask

   // Work out the result word for one accepted sample and advance the state
   function automatic beat_word_t predict_beat_word(logic signed [15:0] s, logic [31:0] now);
      beat_word_t w;
      longint x, mag, f13, thr, gap, iv, med;
      longint sorted [RING_DEPTH];
      longint k;
      int j;
      bit hit;
      x = s;
      hit = 1'b0;
      hp_state = sat32(scale_q15(hp_state + (x - prev_sample) * 128, hp_alpha));
      prev_sample = x;
      lp_state = sat32(lp_state + scale_q15(hp_state - lp_state, lp_alpha));
      mag = (lp_state < 0) ? -lp_state : lp_state;
      f13 = (mag + 64) >>> 7;
      if (lp_state < 0) f13 = -f13;
      if (f13 > 65535) f13 = 65535;
      if (f13 < -65536) f13 = -65536;
      env_level = uscale_q15(env_level, env_decay);
      if (mag > env_level) env_level = mag;
      thr = uscale_q15(env_level, thr_ratio);
      if (thr < thr_floor) thr = thr_floor;
      gap = (longint'(now) - last_beat) & U32_MASK;
      if (prev_mag > mag && prev_mag > thr && gap > refractory) begin
         if (last_beat != 0) begin
            iv = (gap > 65535) ? 65535 : gap;
            if (ring_pos >= RING_DEPTH) ring_pos = 0;
            interval_ring[ring_pos] = iv;
            ring_pos = (ring_pos + 1) % RING_DEPTH;
            if (ring_count < RING_DEPTH) ring_count++;
            for (int i = 0; i < ring_count; i++) sorted[i] = interval_ring[i];
            for (int i = 1; i < ring_count; i++) begin
               k = sorted[i];
               j = i;
               while (j > 0 && sorted[j-1] > k) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end
               sorted[j] = k;
            end
            med = sorted[ring_count / 2];
            if (med == 0) begin
               rate_now = 0;
            end else begin
               rate_now = (960000 + med / 2) / med;
               if (rate_now > 4095) rate_now = 4095;
            end
         end
         last_beat = now;
         beats_seen = (beats_seen + 1) & U32_MASK;
         hit = 1'b1;
      end
      prev_mag = mag;
      gap = (longint'(now) - last_beat) & U32_MASK;
      if (last_beat != 0 && gap > stale_gap) begin
         rate_now = 0;
         ring_count = 0;
         ring_pos = 0;
      end
      w.filtered = f13[16:0];
      w.beat = hit;
      w.rate_x16 = rate_now[11:0];
      w.beat_total = beats_seen[31:0];
      return w;
   endfunction

   // Count cycles and stop a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Drive result ready: random stalls, plus one long hold-off on request
   int stall_left = 0;
   int hold_left = 0;
   initial begin
      rsp.ready = 1'b0;
      req.valid = 1'b0;
      req.accel_sample = '0;
      req.now_ms = '0;
   end
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      beat_word_t e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: filtered %0d", rsp.filtered);
         end else begin
            e = expected_words.pop_front();
            if (rsp.filtered !== e.filtered || rsp.beat !== e.beat ||
                rsp.rate_x16 !== e.rate_x16 || rsp.beat_total !== e.beat_total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp f=%0d b=%0d r=%0d n=%0d got f=%0d b=%0d r=%0d n=%0d",
                           e.filtered, e.beat, e.rate_x16, e.beat_total, rsp.filtered,
                           rsp.beat, rsp.rate_x16, rsp.beat_total);
            end
         end
      end
   end

   // Offer one sample word, with an occasional idle burst first
   task automatic send_sample(logic signed [15:0] s, logic [31:0] now);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.accel_sample <= s;
      req.now_ms <= now;
      do @(posedge clock); while (!req.ready);
      expected_words.push_back(predict_beat_word(s, now));
   endtask

   // Stop sending and wait for every expected word, then let the core settle
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, longint val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DW-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_HP_COEFF:   hp_alpha = val & 16'hFFFF;
         REG_LP_COEFF:   lp_alpha = val & 16'hFFFF;
         REG_ENV_DECAY:  env_decay = val & 16'hFFFF;
         REG_THR_RATIO:  thr_ratio = val & 16'hFFFF;
         REG_THR_FLOOR:  thr_floor = val & 20'hFFFFF;
         REG_REFRACTORY: refractory = val & 16'hFFFF;
         REG_STALE:      stale_gap = val & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic write_all(longint hp, longint lp, longint dec, longint rat, longint flr,
                            longint refr, longint stl);
      write_reg(REG_HP_COEFF, hp);
      write_reg(REG_LP_COEFF, lp);
      write_reg(REG_ENV_DECAY, dec);
      write_reg(REG_THR_RATIO, rat);
      write_reg(REG_THR_FLOOR, flr);
      write_reg(REG_REFRACTORY, refr);
      write_reg(REG_STALE, stl);
   endtask

   // Pulse train: a spike every period samples over noise, some broken samples
   task automatic pulse_train(int n, int step, int period, int amp, int noise);
      logic signed [15:0] s;
      int ph;
      for (int i = 0; i < n; i++) begin
         clock_ms = clock_ms + step + $urandom_range(0, step / 4);
         ph = i % period;
         if ($urandom_range(0, 19) == 0) s = 16'($urandom);
         else if (ph == 0) s = 16'(amp);
         else if (ph == 1) s = 16'(amp / 2);
         else s = 16'(int'($urandom_range(0, 2 * noise)) - noise);
         send_sample(s, clock_ms);
      end
   endtask

   task automatic test_field_extremes();
      logic signed [15:0] edge_vals [6] = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 0, -1};
      foreach (edge_vals[i]) begin
         clock_ms = clock_ms + 1;
         send_sample(edge_vals[i], clock_ms);
      end
      // first beat, then beats across the wrap of the timestamp, one landing at zero
      clock_ms = 32'hFFFF_F000;
      send_sample(16'sd20000, clock_ms);
      for (int i = 0; i < 6; i++) send_sample(0, clock_ms + 4 * (i + 1));
      clock_ms = 32'hFFFF_FFF0;
      send_sample(16'sd20000, clock_ms);
      send_sample(16'sd0, 32'h0000_0000);
      send_sample(16'sd0, 32'h0000_0004);
      send_sample(16'sd20000, 32'd1000);
      send_sample(16'sd0, 32'd1004);
      send_sample(16'sd0, 32'd1008);
      send_sample(16'sd0, 32'h7FFF_FFFF);
      send_sample(16'sd0, 32'hFFFF_FFFF);
      clock_ms = 32'd5000;
      wait_idle();
   endtask

   task automatic test_default_heartbeat();
      for (int k = 0; k < 8; k++)
         pulse_train(50, 10, $urandom_range(45, 110), $urandom_range(3000, 30000), 200);
      // random timestamps and samples to toggle every bit
      for (int i = 0; i < 30; i++) begin
         clock_ms = $urandom;
         send_sample(16'($urandom), clock_ms);
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      pulse_train(80, 10, 60, 12000, 100);
      wait_idle();
   endtask

   task automatic test_fast_rate();
      write_all(32768, 32768, 0, 32768, 0, 0, 65535);
      pulse_train(220, 5, 20, 15000, 50);
      wait_idle();
   endtask

   task automatic test_long_interval();
      write_all(HP_COEFF_RST, LP_COEFF_RST, ENV_DECAY_RST, THR_RATIO_RST, THR_FLOOR_RST,
                400, 65535);
      pulse_train(160, 2000, 36, 20000, 100);
      wait_idle();
   endtask

   task automatic test_wide_coeffs();
      write_all(65535, 65535, 65535, 65535, 1048575, 65535, 0);
      write_reg(3'd7, 0);
      pulse_train(120, 7, 30, 30000, 2000);
      wait_idle();
      write_all(0, 0, 0, 0, 0, 0, 0);
      pulse_train(100, 7, 30, 30000, 2000);
      wait_idle();
      write_all(40000, 20000, 33000, 8000, 500, 300, 1500);
      pulse_train(150, 8, 70, 9000, 300);
      wait_idle();
   endtask

   task automatic test_quiet_tail();
      write_all(HP_COEFF_RST, LP_COEFF_RST, ENV_DECAY_RST, THR_RATIO_RST, THR_FLOOR_RST,
                REFRACTORY_RST, STALE_RST);
      idle_on = 1'b0;
      for (int k = 0; k < 8; k++)
         pulse_train(50, 10, $urandom_range(45, 110), $urandom_range(3000, 30000), 200);
      wait_idle();
   endtask

   initial begin
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_default_heartbeat();
      test_backpressure();
      test_fast_rate();
      test_long_interval();
      test_wide_coeffs();
      test_quiet_tail();
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
